/* hdl/multi_stack_shared_store_macros.svh */
// Assertion macros used by the checker file of the shared-store stack block.
`ifndef MULTI_STACK_SHARED_STORE_MACROS_SVH
`define MULTI_STACK_SHARED_STORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mss assertion failed");

// Next-cycle implication, disabled while in reset
`define MSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mss assertion failed");

`endif

/* hdl/mss_pkg.sv */
// Types, constants and helpers shared by the shared-store stack block.
`default_nettype none

package mss_pkg;

    localparam int NUM_STACKS = 4;
    localparam int CAPACITY   = 64;
    localparam int DATA_W     = 32;
    localparam int SID_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int LINK_W     = ADDR_W + 1;

    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam link_t LINK_NULL = LINK_W'(CAPACITY);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Link store port request
    typedef struct packed {
        logic  we;
        addr_t waddr;
        link_t wdata;
        logic  re;
        addr_t raddr;
    } link_req_t;

    // Data store port request
    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        logic  re;
        addr_t raddr;
    } data_req_t;

    // Any link at or above the capacity means end of list
    function automatic logic link_is_null(input link_t l);
        return 32'(l) >= CAPACITY;
    endfunction

    function automatic logic sid_in_range(input logic [SID_W-1:0] sid);
        return 32'(sid) < NUM_STACKS;
    endfunction

endpackage

`default_nettype wire

/* hdl/mss_ram.sv */
// Generic simple dual-port synchronous RAM with registered read data.
`default_nettype none

module mss_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] q_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            q_reg <= mem[raddr];
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* hdl/mss_ctrl.sv */
// Sequencer: list heads, free head, link valid bits, store requests and result register.
`default_nettype none

module mss_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          opcode,
    input  logic [mss_pkg::SID_W-1:0]     stack_id,
    input  logic signed [mss_pkg::DATA_W-1:0] push_value,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic [mss_pkg::STATUS_W-1:0]  status,
    output logic signed [mss_pkg::DATA_W-1:0] pop_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output mss_pkg::link_req_t            link_req,
    input  mss_pkg::link_t                link_q,
    output mss_pkg::data_req_t            data_req,
    input  mss_pkg::data_t                data_q
);

    import mss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DONE = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    link_t                   free_head_reg, free_head_next;
    link_t                   heads_reg [NUM_STACKS];
    link_t                   heads_next [NUM_STACKS];
    logic [CAPACITY-1:0]     lvalid_reg, lvalid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    data_t                   pop_value_reg, pop_value_next;
    logic                    op_reg;
    logic [SID_W-1:0]        sid_reg;
    addr_t                   slot_reg;
    logic                    ok_reg;

    logic                    accept;
    logic                    finish;
    link_t                   slot_sel;
    logic                    ok_a;
    link_t                   link_val;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign finish    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pop_value = pop_value_reg;

    // Pick the slot the request works on and check it
    always_comb
    begin
        slot_sel = (opcode == OP_POP) ? heads_reg[stack_id] : free_head_reg;
        ok_a     = sid_in_range(stack_id) && !link_is_null(slot_sel);
    end

    // Link of the slot: never-written entries still hold their reset chain
    assign link_val = lvalid_reg[slot_reg] ? link_q : ({1'b0, slot_reg} + LINK_W'(1));

    // Store requests: link read and data read or write at accept, link write-back at finish
    always_comb
    begin
        link_req.re    = accept && ok_a;
        link_req.raddr = slot_sel[ADDR_W-1:0];
        link_req.we    = finish && ok_reg;
        link_req.waddr = slot_reg;
        link_req.wdata = (op_reg == OP_POP) ? free_head_reg : heads_reg[sid_reg];

        data_req.re    = accept && ok_a && (opcode == OP_POP);
        data_req.raddr = slot_sel[ADDR_W-1:0];
        data_req.we    = accept && ok_a && (opcode == OP_PUSH);
        data_req.waddr = slot_sel[ADDR_W-1:0];
        data_req.wdata = data_t'(push_value);
    end

    // Next state of lists and result
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        heads_next     = heads_reg;
        lvalid_next    = lvalid_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        pop_value_next = pop_value_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    pop_value_next = '0;
                    if (!ok_reg)
                    begin
                        status_next = (op_reg == OP_POP) ? ST_EMPTY : ST_FULL;
                    end
                    else
                    begin
                        status_next           = ST_OK;
                        lvalid_next[slot_reg] = 1'b1;
                        if (op_reg == OP_POP)
                        begin
                            heads_next[sid_reg] = link_val;
                            free_head_next      = {1'b0, slot_reg};
                            pop_value_next      = data_q;
                        end
                        else
                        begin
                            free_head_next      = link_val;
                            heads_next[sid_reg] = {1'b0, slot_reg};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                heads_reg[i] <= LINK_NULL;
            end
            lvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            heads_reg     <= heads_next;
            lvalid_reg    <= lvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        pop_value_reg <= pop_value_next;
        if (accept)
        begin
            op_reg   <= opcode;
            sid_reg  <= stack_id;
            slot_reg <= slot_sel[ADDR_W-1:0];
            ok_reg   <= ok_a;
        end
    end

endmodule

`default_nettype wire

/* hdl/multi_stack_shared_store.sv */
// Top level: several LIFO stacks sharing one data store with a linked free list.
`default_nettype none

// Push and pop requests on four stacks that share 64 data slots. On accept
// of a request the slot (free head for a push, stack head for a pop) is read
// from the synchronous link memory, and the data memory is written or read;
// in the done state the link comes back and the free head, the stack head and
// the slot's link are updated and the result is registered. A new request is
// taken only after that update, so a request cannot enter before the previous
// one is through. The result register lets a request enter while the previous
// result waits; the update stalls while that result is still held. Link
// entries not yet written answer their reset chain through per-entry valid
// flops, so no clearing pass follows reset. Status: ok, full (push with no
// free slot), or empty (pop on an empty stack); pop_value is zero except for
// a good pop.
module multi_stack_shared_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          opcode,
    input  logic [mss_pkg::SID_W-1:0]     stack_id,
    input  logic signed [mss_pkg::DATA_W-1:0] push_value,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic [mss_pkg::STATUS_W-1:0]  status,
    output logic signed [mss_pkg::DATA_W-1:0] pop_value,
    output logic                          out_valid,
    input  logic                          out_ready
);

    import mss_pkg::*;

    link_req_t link_req;
    data_req_t data_req;
    link_t     link_q;
    data_t     data_q;

    // Sequencer
    mss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (opcode),
        .stack_id   (stack_id),
        .push_value (push_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .status     (status),
        .pop_value  (pop_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .link_req   (link_req),
        .link_q     (link_q),
        .data_req   (data_req),
        .data_q     (data_q)
    );

    // Link store
    mss_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata),
        .re    (link_req.re),
        .raddr (link_req.raddr),
        .q     (link_q)
    );

    // Data store
    mss_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_req.we),
        .waddr (data_req.waddr),
        .wdata (data_req.wdata),
        .re    (data_req.re),
        .raddr (data_req.raddr),
        .q     (data_q)
    );

endmodule

`default_nettype wire

/* hdl/mss_checker.sv */
// Port-level checker for the shared-store stack block, bound to the top level.
`default_nettype none

`include "multi_stack_shared_store_macros.svh"

module mss_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [mss_pkg::STATUS_W-1:0]  status,
    input  logic signed [mss_pkg::DATA_W-1:0] pop_value,
    input  logic                          out_valid,
    input  logic                          out_ready
);

    import mss_pkg::*;

    logic                       status_known;
    logic                       out_stall;
    logic [STATUS_W+DATA_W-1:0] out_word;

    // Collapse the result port into a few terms for the checks below
    assign status_known = (status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY);
    assign out_stall    = out_valid && !out_ready;
    assign out_word     = {status, pop_value};

    // Only the three defined status codes appear
    `MSS_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status_known)

    // Failed requests return a zero word
    `MSS_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && status != ST_OK, pop_value == '0)

    // One request in flight: no accept right after an accept
    `MSS_ASSERT_NXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready)

    // A stalled result holds
    `MSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

endmodule

bind multi_stack_shared_store mss_checker u_mss_checker (.*);

`default_nettype wire

/* verif/multi_stack_shared_store_tb.sv */
// Self-checking testbench for the shared-store multi-stack block.
`timescale 1ns / 100ps

module multi_stack_shared_store_tb;
    import mss_pkg::*;

    localparam int NUM_REQUESTS = 800;
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 10;
    localparam int DIRECTED_LEN = 24;

    // One directed request, with its result typed in where it is obvious
    typedef struct packed {
        op_t                 op;
        logic [SID_W-1:0]    sid;
        data_t               word;
        logic                typed;
        status_t             exp_status;
        data_t               exp_word;
    } directed_row_t;

    typedef struct {
        status_t status;
        data_t   word;
    } stack_result_t;

    localparam directed_row_t DIRECTED_PLAN [DIRECTED_LEN] = '{
        '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{OP_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{OP_POP,  2'd2, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{OP_POP,  2'd3, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{OP_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd3, 32'h8000_0000, 1'b1, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd1, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd2, 32'h0000_0000, 1'b1, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd0, 32'h5555_5555, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd0, 32'hAAAA_AAAA, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_POP,  2'd0, 32'h1234_5678, 1'b1, ST_OK,    32'hAAAA_AAAA},
        '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, ST_OK,    32'h5555_5555},
        '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, ST_OK,    32'h7FFF_FFFF},
        '{OP_POP,  2'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{OP_POP,  2'd3, 32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000},
        '{OP_POP,  2'd1, 32'h0000_0000, 1'b1, ST_OK,    32'hFFFF_FFFF},
        '{OP_POP,  2'd2, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h0000_0000},
        '{OP_POP,  2'd2, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
        '{OP_PUSH, 2'd1, 32'h1234_5678, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd1, 32'hEDCB_A987, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_POP,  2'd1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_PUSH, 2'd2, 32'h0000_0001, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_POP,  2'd1, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000},
        '{OP_POP,  2'd2, 32'h0000_0000, 1'b0, ST_OK,    32'h0000_0000}
    };

    localparam int PUSH_MIX [5] = '{100, 85, 50, 15, 0};

    logic                    clk;
    logic                    rst_n;
    logic                    opcode;
    logic [SID_W-1:0]        stack_id;
    logic signed [DATA_W-1:0] push_value;
    logic                    in_valid;
    logic                    in_ready;
    logic [STATUS_W-1:0]     status;
    logic signed [DATA_W-1:0] pop_value;
    logic                    out_valid;
    logic                    out_ready;

    // Shadow of the block: slot words, slot links, stack tops, free-list head
    data_t slot_word [CAPACITY];
    link_t slot_link [CAPACITY];
    link_t stack_top [NUM_STACKS];
    link_t free_slot;

    stack_result_t pending_results [$];
    stack_result_t oldest_result;
    int            err_count;
    int            idle_cycles;
    int            stall_left;
    bit            steady_flow;

    multi_stack_shared_store dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (opcode),
        .stack_id   (stack_id),
        .push_value (push_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .status     (status),
        .pop_value  (pop_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Mostly short pauses, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one push or pop to the shadow stacks and return its result
    task automatic predict_stack_op(input op_t op, input logic [SID_W-1:0] sid,
                                    input data_t word, output stack_result_t res);
        int slot;
        res.status = ST_OK;
        res.word   = '0;
        if (op == OP_PUSH)
        begin
            if (free_slot >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                slot            = free_slot;
                free_slot       = slot_link[slot];
                slot_word[slot] = word;
                slot_link[slot] = stack_top[sid];
                stack_top[sid]  = link_t'(slot);
            end
        end
        else
        begin
            if (stack_top[sid] >= CAPACITY)
                res.status = ST_EMPTY;
            else
            begin
                slot            = stack_top[sid];
                stack_top[sid]  = slot_link[slot];
                res.word        = slot_word[slot];
                slot_link[slot] = free_slot;
                free_slot       = link_t'(slot);
            end
        end
    endtask

    // Offer one request, hold it until taken, then queue its expected result
    task automatic issue_request(input op_t op, input logic [SID_W-1:0] sid,
                                 input data_t word, input logic typed,
                                 input status_t exp_status, input data_t exp_word);
        stack_result_t res;
        if (!steady_flow && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_length()) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        stack_id   <= sid;
        push_value <= word;
        do
            @(posedge clk);
        while (!in_ready);
        predict_stack_op(op, sid, word, res);
        if (typed)
        begin
            res.status = exp_status;
            res.word   = exp_word;
        end
        pending_results.push_back(res);
    endtask

    // Hold off the sender until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Receiver: stall at random unless the flow is steady
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (!steady_flow && $urandom_range(0, 3) == 0)
        begin
            stall_left <= idle_length() - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                oldest_result = pending_results.pop_front();
                if (status !== oldest_result.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, oldest_result.status));
                if (pop_value !== oldest_result.word)
                    report_mismatch($sformatf("pop_value %h, expected %h",
                                              pop_value, oldest_result.word));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int      sent;
        int      epoch;
        int      epoch_len;
        int      push_pct;
        op_t     op;
        data_t   word;

        clk         = 1'b0;
        rst_n       = 1'b0;
        opcode      = OP_PUSH;
        stack_id    = '0;
        push_value  = '0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        err_count   = 0;
        idle_cycles = 0;
        stall_left  = 0;
        steady_flow = 1'b0;

        // Reset the shadow: free list threads every slot in order
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_word[i] = '0;
            slot_link[i] = link_t'(i + 1);
        end
        slot_link[CAPACITY-1] = LINK_NULL;
        for (int i = 0; i < NUM_STACKS; i++)
            stack_top[i] = LINK_NULL;
        free_slot = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty pops, word extremes, slot reuse
        for (int i = 0; i < DIRECTED_LEN; i++)
            issue_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].sid, DIRECTED_PLAN[i].word,
                          DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].exp_status,
                          DIRECTED_PLAN[i].exp_word);
        drain_results();

        // Random part: epochs of biased push/pop mix, first one fills, second drains
        sent  = 0;
        epoch = 0;
        while (sent < NUM_REQUESTS)
        begin
            if (epoch == 0)
                push_pct = 100;
            else if (epoch == 1)
                push_pct = 0;
            else
                push_pct = PUSH_MIX[$urandom_range(0, 4)];
            epoch_len   = (epoch < 2) ? 80 : $urandom_range(40, 100);
            steady_flow = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < epoch_len; i++)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                case ($urandom_range(0, 15))
                    0:       word = 32'h7FFF_FFFF;
                    1:       word = 32'h8000_0000;
                    2:       word = 32'hFFFF_FFFF;
                    3:       word = 32'h0000_0000;
                    default: word = $urandom();
                endcase
                issue_request(op, SID_W'($urandom_range(0, NUM_STACKS - 1)), word,
                              1'b0, ST_OK, '0);
                sent++;
            end
            // Let every result come home after the first epoch, then at random
            if (epoch == 0 || $urandom_range(0, 1) == 0)
                drain_results();
            epoch++;
        end
        steady_flow = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
